// File: src/skh_pkg.sv
// skh_pkg: constants shared by the string key hash block and its checker
// no dependencies

package skh_pkg;

    localparam int unsigned MAX_INDEX_BITS_DEF = 12;
    localparam int unsigned LENGTH_BITS_DEF    = 16;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned COUNT_W  = 3;

    localparam logic [HASH_W-1:0] SEED_C  = 32'h1656_67B1;
    localparam logic [HASH_W-1:0] PRIME_A = 32'hC2B2_AE3D;
    localparam logic [HASH_W-1:0] PRIME_B = 32'h27D4_EB2F;
    localparam logic [HASH_W-1:0] PRIME_C = 32'h9E37_79B1;
    localparam logic [HASH_W-1:0] PRIME_D = 32'h85EB_CA77;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd1;

    function automatic logic [HASH_W-1:0] rotl17(input logic [HASH_W-1:0] v);
        rotl17 = {v[HASH_W-18:0], v[HASH_W-1:HASH_W-17]};
    endfunction

    function automatic logic [HASH_W-1:0] rotl11(input logic [HASH_W-1:0] v);
        rotl11 = {v[HASH_W-12:0], v[HASH_W-1:HASH_W-11]};
    endfunction

endpackage

// File: src/string_key_hash_to_bucket.sv
// string_key_hash_to_bucket: top level, sequencer around one shared 32x32 multiplier
// depends on skh_pkg

// Hashes a key given as little-endian 32-bit words, one transfer per word, with
// one 32x32 multiplier reused under a small sequencer; the input is not ready while
// a word is being mixed. A full word takes three dependent multiplies and an add,
// each byte of a short word takes two multiplies, and a word marked last then takes
// the two avalanche multiplies and the hand-off to the output register, which waits
// until that register is free; all share the single multiplier. The result sits in
// an output register, so the next key can start while it waits to be taken.
// index_bits may be written at any idle time and is taken every cycle.

module string_key_hash_to_bucket #(
    parameter int unsigned MAX_INDEX_BITS = skh_pkg::MAX_INDEX_BITS_DEF,
    parameter int unsigned LENGTH_BITS    = skh_pkg::LENGTH_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [skh_pkg::CFG_W-1:0]          cfg_index_bits,
    // key words
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [skh_pkg::HASH_W-1:0]         s_word_bytes,
    input  logic [skh_pkg::COUNT_W-1:0]        s_byte_count,
    input  logic                               s_is_first,
    input  logic                               s_is_last,
    input  logic [LENGTH_BITS-1:0]             s_key_length,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [skh_pkg::INDEX_W-1:0]        m_bucket_index,
    output logic [skh_pkg::HASH_W-1:0]         m_full_hash
);

    localparam int unsigned HW = skh_pkg::HASH_W;
    localparam int unsigned CW = skh_pkg::CFG_W;
    localparam int unsigned MASK_W = 1 << CW;
    localparam logic [CW-1:0] IdxCap =
        (MAX_INDEX_BITS >= MASK_W) ? CW'(MASK_W - 1) : CW'(MAX_INDEX_BITS);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_WORD1 = 10'b00_0000_0010,
        ST_WORD2 = 10'b00_0000_0100,
        ST_WORD3 = 10'b00_0000_1000,
        ST_WADD  = 10'b00_0001_0000,
        ST_BYTE1 = 10'b00_0010_0000,
        ST_BYTE2 = 10'b00_0100_0000,
        ST_AV1   = 10'b00_1000_0000,
        ST_AV2   = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [HW-1:0] hash_reg, hash_next;     // running hash, pre-avalanche
    logic [HW-1:0] prod_reg, prod_next;
    logic [HW-1:0] word_reg, word_next;
    logic [1:0]    rem_reg, rem_next;       // bytes left in a short word
    logic          last_reg, last_next;
    logic [CW-1:0] idx_reg;

    logic          m_valid_reg, m_valid_next;
    logic [skh_pkg::INDEX_W-1:0] bucket_reg, bucket_next;
    logic [HW-1:0] full_reg, full_next;

    logic [HW-1:0]   mul_a, mul_b;
    logic [2*HW-1:0] mul_full;
    logic [HW-1:0]   mul_p;
    logic [HW-1:0]   fin_hash;
    logic [CW-1:0]   idx_used;
    logic [MASK_W-1:0] idx_mask;
    logic          out_free;
    logic          s_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // the one shared multiplier, operands picked by the sequencer
    always_comb begin
        mul_a = hash_reg;
        mul_b = skh_pkg::PRIME_C;
        unique case (state_reg)
            ST_WORD1: begin
                mul_a = word_reg;
                mul_b = skh_pkg::PRIME_A;
            end
            ST_WORD2: begin
                mul_a = skh_pkg::rotl17(prod_reg);
                mul_b = skh_pkg::PRIME_B;
            end
            ST_WORD3: begin
                mul_a = skh_pkg::rotl17(hash_reg ^ prod_reg);
                mul_b = skh_pkg::PRIME_C;
            end
            ST_BYTE1: begin
                // key byte taken as a signed char
                mul_a = {{(HW-8){word_reg[7]}}, word_reg[7:0]};
                mul_b = skh_pkg::SEED_C;
            end
            ST_BYTE2: begin
                mul_a = skh_pkg::rotl11(hash_reg + prod_reg);
                mul_b = skh_pkg::PRIME_C;
            end
            ST_AV1: begin
                mul_a = hash_reg ^ (hash_reg >> 15);
                mul_b = skh_pkg::PRIME_D;
            end
            ST_AV2: begin
                mul_a = prod_reg ^ (prod_reg >> 13);
                mul_b = skh_pkg::PRIME_A;
            end
            default: begin
                mul_a = hash_reg;
                mul_b = skh_pkg::PRIME_C;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[HW-1:0];

    assign fin_hash = prod_reg ^ (prod_reg >> 16);
    assign idx_used = (idx_reg < IdxCap) ? idx_reg : IdxCap;
    assign idx_mask = (MASK_W'(1) << idx_used) - MASK_W'(1);

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        prod_next    = prod_reg;
        word_next    = word_reg;
        rem_next     = rem_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        bucket_next  = bucket_reg;
        full_next    = full_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    word_next = s_word_bytes;
                    last_next = s_is_last;
                    rem_next  = s_byte_count[1:0];
                    if (s_is_first) begin
                        hash_next = skh_pkg::SEED_C + HW'(s_key_length);
                    end
                    if (s_byte_count[2]) begin
                        state_next = ST_WORD1;
                    end else if (s_byte_count[1:0] != 2'd0) begin
                        state_next = ST_BYTE1;
                    end else if (s_is_last) begin
                        state_next = ST_AV1;
                    end
                end
            end
            ST_WORD1: begin
                prod_next  = mul_p;
                state_next = ST_WORD2;
            end
            ST_WORD2: begin
                prod_next  = mul_p;
                state_next = ST_WORD3;
            end
            ST_WORD3: begin
                hash_next  = mul_p;
                state_next = ST_WADD;
            end
            ST_WADD: begin
                hash_next  = hash_reg + skh_pkg::PRIME_B;
                state_next = last_reg ? ST_AV1 : ST_IDLE;
            end
            ST_BYTE1: begin
                prod_next  = mul_p;
                state_next = ST_BYTE2;
            end
            ST_BYTE2: begin
                hash_next = mul_p;
                word_next = word_reg >> 8;
                rem_next  = rem_reg - 2'd1;
                if (rem_reg == 2'd1) begin
                    state_next = last_reg ? ST_AV1 : ST_IDLE;
                end else begin
                    state_next = ST_BYTE1;
                end
            end
            ST_AV1: begin
                prod_next  = mul_p;
                state_next = ST_AV2;
            end
            ST_AV2: begin
                prod_next  = mul_p;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait here until the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    full_next    = fin_hash;
                    bucket_next  = fin_hash[skh_pkg::INDEX_W-1:0]
                                 & idx_mask[skh_pkg::INDEX_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hash_reg    <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= skh_pkg::INDEX_BITS_RESET;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                idx_reg <= cfg_index_bits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        word_reg   <= word_next;
        rem_reg    <= rem_next;
        last_reg   <= last_next;
        bucket_reg <= bucket_next;
        full_reg   <= full_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket_index = bucket_reg;
    assign m_full_hash    = full_reg;

endmodule

// File: src/skh_checker.sv
// skh_checker: port-level checks on the string key hash block, bound to its top level
// depends on skh_pkg

module skh_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [skh_pkg::COUNT_W-1:0] s_byte_count,
    input logic                        s_is_last,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [skh_pkg::INDEX_W-1:0] m_bucket_index,
    input logic [skh_pkg::HASH_W-1:0]  m_full_hash
);

    // a word with bytes to mix, or one that ends a key, keeps the block busy
    // for at least the following cycle
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_byte_count != '0 || s_is_last) |=> !s_ready)
        else $error("input ready straight after a word transfer");

    // a result that is not taken holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_full_hash) && $stable(m_bucket_index))
        else $error("result changed or dropped before transfer");

    // the bucket is only ever a masked copy of the hash
    a_bucket_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bucket_index & ~m_full_hash[skh_pkg::INDEX_W-1:0]) == '0)
        else $error("bucket index has bits not in the hash");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind string_key_hash_to_bucket skh_checker u_skh_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_byte_count   (s_byte_count),
    .s_is_last      (s_is_last),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bucket_index (m_bucket_index),
    .m_full_hash    (m_full_hash)
);
